[rtl/core/lsrns_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrns_pkg
// Types and constants shared by the LCD screen refresh nibble streamer.
// ----------------------------------------------------------------------------
package lsrns_pkg;

  localparam int unsigned IdxW        = 5;
  localparam int unsigned CharW       = 8;
  localparam int unsigned NibW        = 4;
  localparam int unsigned BufDepth    = 32;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned InDataW     = 16;
  localparam int unsigned OutDataW    = 8;

  // op field codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // high nibble of the set-address command for each line; the low nibble is zero
  localparam logic [NibW-1:0] CMD_HI_LINE_ONE = 4'h8;
  localparam logic [NibW-1:0] CMD_HI_LINE_TWO = 4'hC;
  localparam logic [NibW-1:0] CMD_LO          = 4'h0;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [IdxW-1:0]        idx;
    logic [CharW-1:0]       chr;
  } cmd_t;

endpackage

[rtl/core/lsrns_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrns_front
// Accepts input transactions, drops ticks while the display is not ready and
// queues writes and live ticks in a two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module lsrns_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic [lsrns_pkg::IdxW-1:0]       write_index_i,
  input  logic [lsrns_pkg::CharW-1:0]      write_char_i,
  input  logic                             display_ready_i,
  output logic                             cmd_valid_o,
  output lsrns_pkg::cmd_t                  cmd_o,
  input  logic                             cmd_pop_i
);

  lsrns_pkg::cmd_t entry_q [lsrns_pkg::QueueDepth];
  lsrns_pkg::cmd_t new_cmd;
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            accept;
  logic            push;
  logic            pop;

  assign in_ready_o = (count_q != 2'(lsrns_pkg::QueueDepth));
  assign accept     = in_valid_i && in_ready_o;
  // a tick while the display is not ready has no effect: drop it here
  assign push       = accept && ((op_i == lsrns_pkg::OP_WRITE) || display_ready_i);
  assign pop        = cmd_pop_i && cmd_valid_o;

  always_comb begin
    new_cmd.kind = (op_i == lsrns_pkg::OP_WRITE) ? lsrns_pkg::CMD_WRITE : lsrns_pkg::CMD_TICK;
    new_cmd.idx  = write_index_i;
    new_cmd.chr  = write_char_i;
  end

  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_cmd;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(lsrns_pkg::QueueDepth))
    else $error("command queue overfilled");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 2'd1))
    else $error("command queue count lost a push");
`endif

endmodule

[rtl/core/lsrns_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrns_back
// Executes queued commands: writes update the screen buffer, ticks emit one
// nibble each into the output register, loading a character when none is
// pending and prefixing a set-address command at each line start.
// ----------------------------------------------------------------------------
module lsrns_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  input  lsrns_pkg::cmd_t                  cmd_i,
  output logic                             cmd_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lsrns_pkg::NibW-1:0]       nibble_o,
  output logic                             register_select_o
);

  logic [lsrns_pkg::CharW-1:0] buf_q [lsrns_pkg::BufDepth];
  logic [lsrns_pkg::IdxW-1:0]  pos_q, pos_d;
  logic [2:0]                  left_q, left_d;
  logic [lsrns_pkg::NibW-1:0]  pend_q [3];
  logic [lsrns_pkg::NibW-1:0]  pend_d [3];
  logic                        out_valid_q;
  logic [lsrns_pkg::NibW-1:0]  out_nib_q, nib;
  logic                        out_rs_q, rs;
  logic                        out_free;
  logic                        tick_go;
  logic                        wr_go;
  logic [lsrns_pkg::CharW-1:0] ch;
  logic                        line_start;
  logic [2:0]                  left_m1;

  assign out_free  = !out_valid_q || out_ready_i;
  assign wr_go     = cmd_valid_i && (cmd_i.kind == lsrns_pkg::CMD_WRITE);
  assign tick_go   = cmd_valid_i && (cmd_i.kind == lsrns_pkg::CMD_TICK) && out_free;
  assign cmd_pop_o = wr_go || tick_go;

  assign ch         = buf_q[pos_q];
  assign line_start = (pos_q[3:0] == 4'd0);
  assign left_m1    = left_q - 3'd1;

  always_comb begin
    pos_d  = pos_q;
    left_d = left_q;
    pend_d = pend_q;
    nib    = pend_q[left_m1[1:0]];
    rs     = (left_q < 3'd3);
    if (left_q == 3'd0) begin
      pos_d     = pos_q + 5'd1;
      pend_d[0] = ch[3:0];
      if (line_start) begin
        // set-address command first; character follows
        nib       = pos_q[4] ? lsrns_pkg::CMD_HI_LINE_TWO : lsrns_pkg::CMD_HI_LINE_ONE;
        rs        = 1'b0;
        left_d    = 3'd3;
        pend_d[2] = lsrns_pkg::CMD_LO;
        pend_d[1] = ch[7:4];
      end else begin
        nib    = ch[7:4];
        rs     = 1'b1;
        left_d = 3'd1;
      end
    end else begin
      left_d = left_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lsrns_pkg::BufDepth; i++) begin
        buf_q[i] <= '0;
      end
      pos_q       <= '0;
      left_q      <= 3'd0;
      pend_q      <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (wr_go) begin
        buf_q[cmd_i.idx] <= cmd_i.chr;
      end
      if (tick_go) begin
        pos_q  <= pos_d;
        left_q <= left_d;
        pend_q <= pend_d;
      end
      if (out_free) begin
        out_valid_q <= tick_go;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_go) begin
      out_nib_q <= nib;
      out_rs_q  <= rs;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign nibble_o          = out_nib_q;
  assign register_select_o = out_rs_q;

`ifndef NO_ASSERTIONS
  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= 3'd3)
    else $error("pending nibble count out of range");

  a_line_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_go && (left_q == 3'd0) && line_start) |=> (out_valid_q && !out_rs_q))
    else $error("line start did not emit a command nibble");
`endif

endmodule

[rtl/core/lcd_screen_refresh_nibble_streamer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_screen_refresh_nibble_streamer_unit
// Streams a 2x16 character screen buffer to a 4-bit LCD bus, one nibble per
// ready tick, with a set-address command at each line start.
// ----------------------------------------------------------------------------
// The block takes one input transaction per clock cycle while s_axis_tready_o
// is high. A write stores a character in the 32-entry screen buffer and gives
// no output; a tick with display_ready low is dropped; a tick with
// display_ready high yields exactly one nibble. A live tick is registered in
// the two-entry command queue, and its nibble is registered at the edge where
// the back end takes the tick from the queue. Throughput is one item per cycle
// without master stalls, set by the back end which retires one command per
// cycle; when the master side stalls, the queue fills with up to two live
// items and s_axis_tready_o drops. Reset clears buffer and state, no sweep.
module lcd_screen_refresh_nibble_streamer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [4:0] write_index, [12:5] write_char,
                                       // [13] display_ready, [15:14] zero
  input  logic       s_axis_tuser_i,   // [0] op
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [3:0] nibble, [7:4] zero
  output logic       m_axis_tuser_o    // [0] register_select
);

  logic                            cmd_valid;
  lsrns_pkg::cmd_t                 cmd;
  logic                            cmd_pop;
  logic [lsrns_pkg::NibW-1:0]      nibble;

  lsrns_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .op_i            (s_axis_tuser_i),
    .write_index_i   (s_axis_tdata_i[4:0]),
    .write_char_i    (s_axis_tdata_i[12:5]),
    .display_ready_i (s_axis_tdata_i[13]),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  lsrns_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_valid_i       (cmd_valid),
    .cmd_i             (cmd),
    .cmd_pop_o         (cmd_pop),
    .out_valid_o       (m_axis_tvalid_o),
    .out_ready_i       (m_axis_tready_i),
    .nibble_o          (nibble),
    .register_select_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {4'd0, nibble};

endmodule
